[hw/rtl/twsd_pkg.sv]
// ----------------------------------------------------------------------------
// twsd_pkg
// Shared types, constants and helper functions of the tile dispatcher.
// ----------------------------------------------------------------------------
package twsd_pkg;

   localparam int MAX_WORKERS       = 16;
   localparam int MAX_TILES         = 4096;
   localparam int SAMPLES_PER_PIXEL = 16;
   localparam int TILE_WIDTH        = 32;

   // Samples one tile holds before its owner counts as exhausted.
   localparam int LIMIT       = SAMPLES_PER_PIXEL * TILE_WIDTH * TILE_WIDTH;
   localparam int MORTON_BITS = $clog2(TILE_WIDTH);
   localparam int SPP_W       = $clog2(SAMPLES_PER_PIXEL);
   localparam int CNT_W       = $clog2(LIMIT + 2);
   localparam int IDX_W       = $clog2(LIMIT);
   localparam int WID_W       = $clog2(MAX_WORKERS);
   localparam int TADDR_W     = $clog2(MAX_TILES);

   // Port widths fixed by the interface.
   localparam int KIND_W   = 2;
   localparam int WORKER_W = 4;
   localparam int TILE_W   = 12;
   localparam int COORD_W  = 16;
   localparam int SMP_W    = 4;
   localparam int PASS_W   = 32;
   localparam int TCNT_W   = 13;
   localparam int WCNT_W   = 5;
   localparam int CSR_W    = 13;
   localparam int CSR_IDX_W = 1;

   typedef enum logic [KIND_W-1:0] {
      KIND_REQUEST = 2'd0,
      KIND_FRAME   = 2'd1,
      KIND_LOAD    = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TILE_COUNT   = 1'd0,
      CSR_WORKER_COUNT = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic [TILE_W-1:0] tile;
      logic [CNT_W-1:0]  count;
   } worker_entry_type;

   typedef struct packed {
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] x;
   } offset_entry_type;

   localparam logic [CNT_W-1:0] CNT_LIMIT     = CNT_W'(LIMIT);
   localparam logic [CNT_W-1:0] CNT_EXHAUSTED = CNT_W'(LIMIT + 1);

   // Saturating sample counter increment.
   function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
      bump = (c > CNT_LIMIT) ? CNT_EXHAUSTED : c + CNT_W'(1);
   endfunction

   // Morton decode: x from the even bits, y from the odd bits.
   function automatic logic [MORTON_BITS-1:0] morton_x(
      input logic [2*MORTON_BITS-1:0] d);
      logic [MORTON_BITS-1:0] r;
      for (int k = 0; k < MORTON_BITS; k++) begin
         r[k] = d[2*k];
      end
      morton_x = r;
   endfunction

   function automatic logic [MORTON_BITS-1:0] morton_y(
      input logic [2*MORTON_BITS-1:0] d);
      logic [MORTON_BITS-1:0] r;
      for (int k = 0; k < MORTON_BITS; k++) begin
         r[k] = d[2*k+1];
      end
      morton_y = r;
   endfunction

endpackage

[hw/rtl/twsd_ram.sv]
// ----------------------------------------------------------------------------
// twsd_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module twsd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // A read of the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[hw/rtl/tile_work_stealing_dispatcher.sv]
// ----------------------------------------------------------------------------
// tile_work_stealing_dispatcher
// Hands pixel work to render workers, with tile refill and work stealing.
// ----------------------------------------------------------------------------
// Usage:
// The req_ channel carries commands. A work request (kind KIND_REQUEST) names
// a worker and yields exactly one transfer on the rsp_ channel: the pixel the
// worker should sample next, or found low when no work is left anywhere. A
// frame start (KIND_FRAME) rewinds the tile counter once every tile has been
// handed out and advances the pass count. A tile load (KIND_LOAD) writes one
// tile's pixel offset into the offset table. Frame, load and the unused kind
// produce no result.
// A work request runs from its transfer to its result in these steps when the
// worker's own tile still has samples or a fresh tile is available: read the
// worker table, decide and read the offset table, form the pixel. When
// stealing, the scan reads one worker table entry per cycle and visits at most
// 16 workers, since the scan never covers more workers than the table holds.
// The single worker table read port sets this rate; one request is in flight
// at a time, and the next command is taken the cycle after its result is
// registered.
// Reset clears the control state at once; there is no clearing pass. Sample
// counters read as exhausted until first written, which valid bits track.
// A result waiting on a stalled receiver sits in the output register while
// new commands are still accepted; a further result waits in the final step
// until the register frees up.
// ----------------------------------------------------------------------------
module tile_work_stealing_dispatcher (
   input  logic                              clock,
   input  logic                              reset,
   // Command channel.
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [twsd_pkg::KIND_W-1:0]       req_kind,
   input  logic [twsd_pkg::WORKER_W-1:0]     req_worker,
   input  logic [twsd_pkg::TILE_W-1:0]       req_tile_number,
   input  logic [twsd_pkg::COORD_W-1:0]      req_offset_x,
   input  logic [twsd_pkg::COORD_W-1:0]      req_offset_y,
   // Result channel.
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_found,
   output logic [twsd_pkg::COORD_W-1:0]      rsp_pixel_x,
   output logic [twsd_pkg::COORD_W-1:0]      rsp_pixel_y,
   output logic [twsd_pkg::TILE_W-1:0]       rsp_assigned_tile,
   output logic [twsd_pkg::SMP_W-1:0]        rsp_sample_in_pixel,
   output logic [twsd_pkg::PASS_W-1:0]       rsp_pass_base,
   // Configuration writes.
   input  logic                              csr_wen,
   input  logic [twsd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [twsd_pkg::CSR_W-1:0]        csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_OWN,
      ST_SCAN,
      ST_FIN
   } state_type;

   state_type state_ff, state_in;

   logic [twsd_pkg::TCNT_W-1:0]      tile_count_ff, tile_count_in;
   logic [twsd_pkg::WCNT_W-1:0]      worker_count_ff, worker_count_in;
   logic [twsd_pkg::TCNT_W-1:0]      next_tile_ff, next_tile_in;
   logic [twsd_pkg::PASS_W-1:0]      pass_count_ff, pass_count_in;
   logic [twsd_pkg::MAX_WORKERS-1:0] valid_ff, valid_in;
   logic [twsd_pkg::WID_W-1:0]       worker_ff, worker_in;
   logic [twsd_pkg::WID_W-1:0]       scan_ff, scan_in;
   logic                             found_ff, found_in;
   logic [twsd_pkg::TILE_W-1:0]      tile_ff, tile_in;
   logic [twsd_pkg::IDX_W-1:0]       idx_ff, idx_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_found_ff, rsp_found_in;
   logic [twsd_pkg::COORD_W-1:0]     rsp_pixel_x_ff, rsp_pixel_x_in;
   logic [twsd_pkg::COORD_W-1:0]     rsp_pixel_y_ff, rsp_pixel_y_in;
   logic [twsd_pkg::TILE_W-1:0]      rsp_tile_ff, rsp_tile_in;
   logic [twsd_pkg::SMP_W-1:0]       rsp_sample_ff, rsp_sample_in;
   logic [twsd_pkg::PASS_W-1:0]      rsp_pass_ff, rsp_pass_in;

   // Worker table: tile and sample counter per worker.
   logic                             wram_wr_en, wram_rd_en;
   logic [twsd_pkg::WID_W-1:0]       wram_wr_addr, wram_rd_addr;
   twsd_pkg::worker_entry_type       wram_wr_data, wram_rd_data;

   // Offset table: pixel offset per tile.
   logic                             oram_wr_en, oram_rd_en;
   logic [twsd_pkg::TADDR_W-1:0]     oram_wr_addr, oram_rd_addr;
   twsd_pkg::offset_entry_type       oram_wr_data, oram_rd_data;

   logic [twsd_pkg::TCNT_W-1:0]      eff_tiles;
   logic [twsd_pkg::WCNT_W-1:0]      scan_len;
   logic [twsd_pkg::CNT_W-1:0]       own_cnt, scan_cnt;
   logic                             scan_last;
   logic [twsd_pkg::IDX_W-twsd_pkg::SPP_W-1:0] digit;

   twsd_ram #(
      .WIDTH ($bits(twsd_pkg::worker_entry_type)),
      .DEPTH (twsd_pkg::MAX_WORKERS)
   ) u_worker_ram (
      .clock   (clock),
      .wr_en   (wram_wr_en),
      .wr_addr (wram_wr_addr),
      .wr_data (wram_wr_data),
      .rd_en   (wram_rd_en),
      .rd_addr (wram_rd_addr),
      .rd_data (wram_rd_data)
   );

   twsd_ram #(
      .WIDTH ($bits(twsd_pkg::offset_entry_type)),
      .DEPTH (twsd_pkg::MAX_TILES)
   ) u_offset_ram (
      .clock   (clock),
      .wr_en   (oram_wr_en),
      .wr_addr (oram_wr_addr),
      .wr_data (oram_wr_data),
      .rd_en   (oram_rd_en),
      .rd_addr (oram_rd_addr),
      .rd_data (oram_rd_data)
   );

   // Clamp the configured counts to what the tables hold.
   assign eff_tiles = (tile_count_ff > twsd_pkg::TCNT_W'(twsd_pkg::MAX_TILES)) ?
                      twsd_pkg::TCNT_W'(twsd_pkg::MAX_TILES) : tile_count_ff;
   assign scan_len  = (worker_count_ff > twsd_pkg::WCNT_W'(twsd_pkg::MAX_WORKERS)) ?
                      twsd_pkg::WCNT_W'(twsd_pkg::MAX_WORKERS) : worker_count_ff;

   // A worker never written reads as exhausted, whatever the table holds.
   assign own_cnt = valid_ff[worker_ff] ? wram_rd_data.count : twsd_pkg::CNT_EXHAUSTED;

   // The requester's own entry was written in the cycle the scan read of
   // entry zero was issued, so that read may be stale. Its counter is known
   // to be exhausted at that point, so it is skipped outright.
   assign scan_cnt = (scan_ff == worker_ff || !valid_ff[scan_ff]) ?
                     twsd_pkg::CNT_EXHAUSTED : wram_rd_data.count;
   assign scan_last = (twsd_pkg::WCNT_W'(scan_ff) + twsd_pkg::WCNT_W'(1)) >= scan_len;

   // Sample number divided by samples per pixel, as Morton digits.
   assign digit = idx_ff[twsd_pkg::IDX_W-1:twsd_pkg::SPP_W];

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in        = state_ff;
      tile_count_in   = tile_count_ff;
      worker_count_in = worker_count_ff;
      next_tile_in    = next_tile_ff;
      pass_count_in   = pass_count_ff;
      valid_in        = valid_ff;
      worker_in       = worker_ff;
      scan_in         = scan_ff;
      found_in        = found_ff;
      tile_in         = tile_ff;
      idx_in          = idx_ff;

      rsp_valid_in    = rsp_valid_ff;
      rsp_found_in    = rsp_found_ff;
      rsp_pixel_x_in  = rsp_pixel_x_ff;
      rsp_pixel_y_in  = rsp_pixel_y_ff;
      rsp_tile_in     = rsp_tile_ff;
      rsp_sample_in   = rsp_sample_ff;
      rsp_pass_in     = rsp_pass_ff;

      wram_rd_en      = 1'b0;
      wram_rd_addr    = req_worker[twsd_pkg::WID_W-1:0];
      wram_wr_en      = 1'b0;
      wram_wr_addr    = worker_ff;
      wram_wr_data    = wram_rd_data;

      oram_rd_en      = 1'b0;
      oram_rd_addr    = wram_rd_data.tile[twsd_pkg::TADDR_W-1:0];
      oram_wr_en      = 1'b0;
      oram_wr_addr    = req_tile_number[twsd_pkg::TADDR_W-1:0];
      oram_wr_data.x  = req_offset_x;
      oram_wr_data.y  = req_offset_y;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wen) begin
         unique case (csr_index)
            twsd_pkg::CSR_TILE_COUNT: begin
               tile_count_in = csr_wdata[twsd_pkg::TCNT_W-1:0];
            end
            twsd_pkg::CSR_WORKER_COUNT: begin
               worker_count_in = csr_wdata[twsd_pkg::WCNT_W-1:0];
            end
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               worker_in = req_worker[twsd_pkg::WID_W-1:0];
               unique case (req_kind)
                  twsd_pkg::KIND_REQUEST: begin
                     wram_rd_en = 1'b1;
                     state_in   = ST_OWN;
                  end
                  twsd_pkg::KIND_FRAME: begin
                     if (next_tile_ff >= eff_tiles) begin
                        next_tile_in  = '0;
                        pass_count_in = pass_count_ff +
                                        twsd_pkg::PASS_W'(twsd_pkg::SAMPLES_PER_PIXEL);
                     end
                  end
                  twsd_pkg::KIND_LOAD: begin
                     oram_wr_en = 1'b1;
                  end
                  default: ;
               endcase
            end
         end

         ST_OWN: begin
            wram_wr_en          = 1'b1;
            wram_wr_addr        = worker_ff;
            valid_in[worker_ff] = 1'b1;
            if (own_cnt < twsd_pkg::CNT_LIMIT) begin
               // Own tile still has samples.
               wram_wr_data.count = twsd_pkg::bump(own_cnt);
               found_in           = 1'b1;
               tile_in            = wram_rd_data.tile;
               idx_in             = own_cnt[twsd_pkg::IDX_W-1:0];
               oram_rd_en         = 1'b1;
               state_in           = ST_FIN;
            end else if (next_tile_ff < eff_tiles) begin
               // Take a fresh tile from the global pool.
               wram_wr_data.tile  = next_tile_ff[twsd_pkg::TILE_W-1:0];
               wram_wr_data.count = twsd_pkg::CNT_W'(1);
               next_tile_in       = next_tile_ff + twsd_pkg::TCNT_W'(1);
               found_in           = 1'b1;
               tile_in            = next_tile_ff[twsd_pkg::TILE_W-1:0];
               idx_in             = '0;
               oram_rd_en         = 1'b1;
               oram_rd_addr       = next_tile_ff[twsd_pkg::TADDR_W-1:0];
               state_in           = ST_FIN;
            end else begin
               // Pool is empty: steal, scanning workers in index order.
               wram_wr_data.count = twsd_pkg::CNT_EXHAUSTED;
               found_in           = 1'b0;
               scan_in            = '0;
               if (scan_len == '0) begin
                  state_in = ST_FIN;
               end else begin
                  wram_rd_en   = 1'b1;
                  wram_rd_addr = '0;
                  state_in     = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // A victim at or below the limit is bumped even if it turns
            // out to hold no sample of its own.
            if (scan_cnt <= twsd_pkg::CNT_LIMIT) begin
               wram_wr_en         = 1'b1;
               wram_wr_addr       = scan_ff;
               wram_wr_data.count = twsd_pkg::bump(scan_cnt);
            end
            if (scan_cnt < twsd_pkg::CNT_LIMIT) begin
               found_in   = 1'b1;
               tile_in    = wram_rd_data.tile;
               idx_in     = scan_cnt[twsd_pkg::IDX_W-1:0];
               oram_rd_en = 1'b1;
               state_in   = ST_FIN;
            end else if (scan_last) begin
               state_in = ST_FIN;
            end else begin
               scan_in      = scan_ff + twsd_pkg::WID_W'(1);
               wram_rd_en   = 1'b1;
               wram_rd_addr = scan_ff + twsd_pkg::WID_W'(1);
            end
         end

         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_pass_in  = pass_count_ff;
               if (found_ff) begin
                  rsp_pixel_x_in = oram_rd_data.x +
                                   twsd_pkg::COORD_W'(twsd_pkg::morton_x(digit));
                  rsp_pixel_y_in = oram_rd_data.y +
                                   twsd_pkg::COORD_W'(twsd_pkg::morton_y(digit));
                  rsp_tile_in    = tile_ff;
                  rsp_sample_in  = twsd_pkg::SMP_W'(
                                   idx_ff % twsd_pkg::IDX_W'(twsd_pkg::SAMPLES_PER_PIXEL));
               end else begin
                  rsp_pixel_x_in = '0;
                  rsp_pixel_y_in = '0;
                  rsp_tile_in    = '0;
                  rsp_sample_in  = '0;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         tile_count_ff   <= twsd_pkg::TCNT_W'(1);
         worker_count_ff <= twsd_pkg::WCNT_W'(1);
         next_tile_ff    <= '0;
         pass_count_ff   <= '0;
         valid_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         tile_count_ff   <= tile_count_in;
         worker_count_ff <= worker_count_in;
         next_tile_ff    <= next_tile_in;
         pass_count_ff   <= pass_count_in;
         valid_ff        <= valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      worker_ff      <= worker_in;
      scan_ff        <= scan_in;
      found_ff       <= found_in;
      tile_ff        <= tile_in;
      idx_ff         <= idx_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_pixel_x_ff <= rsp_pixel_x_in;
      rsp_pixel_y_ff <= rsp_pixel_y_in;
      rsp_tile_ff    <= rsp_tile_in;
      rsp_sample_ff  <= rsp_sample_in;
      rsp_pass_ff    <= rsp_pass_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_found           = rsp_found_ff;
   assign rsp_pixel_x         = rsp_pixel_x_ff;
   assign rsp_pixel_y         = rsp_pixel_y_ff;
   assign rsp_assigned_tile   = rsp_tile_ff;
   assign rsp_sample_in_pixel = rsp_sample_ff;
   assign rsp_pass_base       = rsp_pass_ff;

endmodule

[hw/rtl/twsd_checker.sv]
// ----------------------------------------------------------------------------
// twsd_checker
// Port-level checks of the tile dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
module twsd_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [twsd_pkg::KIND_W-1:0]       req_kind,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_found,
   input logic [twsd_pkg::COORD_W-1:0]      rsp_pixel_x,
   input logic [twsd_pkg::COORD_W-1:0]      rsp_pixel_y,
   input logic [twsd_pkg::TILE_W-1:0]       rsp_assigned_tile,
   input logic [twsd_pkg::SMP_W-1:0]        rsp_sample_in_pixel,
   input logic [twsd_pkg::PASS_W-1:0]       rsp_pass_base
);

   // A stalled result keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_found) &&
      $stable(rsp_pixel_x) && $stable(rsp_pixel_y) &&
      $stable(rsp_assigned_tile) && $stable(rsp_sample_in_pixel) &&
      $stable(rsp_pass_base))
      else $error("result changed while stalled");

   // A taken work request closes the command channel.
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind == twsd_pkg::KIND_REQUEST |=> !req_ready)
      else $error("command taken while a request is in flight");

   // A not-found result carries no pixel.
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_pixel_x == '0 && rsp_pixel_y == '0 &&
      rsp_assigned_tile == '0 && rsp_sample_in_pixel == '0)
      else $error("not-found result with pixel data");

   // No result is presented right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind tile_work_stealing_dispatcher twsd_checker u_twsd_checker (.*);
